/* sv/psu_pkg.sv */
package psu_pkg;

  localparam int BYTE_W       = 8;
  localparam int ROW_PIXELS_W = 11;
  localparam int IMAGE_ROWS_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;

  localparam int MAX_WIDTH_DEF       = 1024;
  localparam int ROW_STORE_DEPTH_DEF = 3072;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_MODE = 2'd2;

  typedef logic [2:0] filter_t;

  localparam filter_t FILT_NONE  = 3'd0;
  localparam filter_t FILT_SUB   = 3'd1;
  localparam filter_t FILT_UP    = 3'd2;
  localparam filter_t FILT_AVG   = 3'd3;
  localparam filter_t FILT_PAETH = 3'd4;

  localparam logic [BYTE_W-1:0] FILT_MAX_CODE = 8'd4;

  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [BYTE_W-1:0] c);
    logic signed [BYTE_W+2:0] p;
    logic signed [BYTE_W+2:0] da;
    logic signed [BYTE_W+2:0] db;
    logic signed [BYTE_W+2:0] dc;
    logic [BYTE_W+2:0] pa;
    logic [BYTE_W+2:0] pb;
    logic [BYTE_W+2:0] pc;
    logic [BYTE_W-1:0] res;
    p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
    da = p - $signed({3'b000, a});
    db = p - $signed({3'b000, b});
    dc = p - $signed({3'b000, c});
    pa = (da < 0) ? $unsigned(-da) : $unsigned(da);
    pb = (db < 0) ? $unsigned(-db) : $unsigned(db);
    pc = (dc < 0) ? $unsigned(-dc) : $unsigned(dc);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

/* sv/psu_ram.sv */
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/png_scanline_unfilter_unit.sv */
// A sample byte is registered in the compute stage (p1), then in the output register;
// out_tready back-pressure can hold it in either. Throughput: one input byte per cycle
// unless out_tready stalls the compute stage; the line store is read once at acceptance
// and written once when the reconstructed byte leaves the compute stage.
// Aborted-image and valid filter-type bytes give no output; a bad one flags bad_filter.
// Reset (rst_n low, synchronous) clears counters, histories, error flag and valid bits;
// the line store is not cleared and needs no clearing pass.
module png_scanline_unfilter_unit #(
  parameter int MAX_WIDTH       = psu_pkg::MAX_WIDTH_DEF,
  parameter int ROW_STORE_DEPTH = psu_pkg::ROW_STORE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  logic [0:0]                      in_tuser,   // [0] image_start
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] pixel_byte
  output logic                            out_tlast,
  output logic [1:0]                      out_tuser,  // [0] end_of_image, [1] bad_filter
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int BW    = psu_pkg::BYTE_W;
  localparam int RPW   = psu_pkg::ROW_PIXELS_W;
  localparam int IRW   = psu_pkg::IMAGE_ROWS_W;
  localparam int AW    = $clog2(ROW_STORE_DEPTH);
  localparam int CNT_W = $clog2(ROW_STORE_DEPTH + 1);
  localparam int PW    = $clog2(MAX_WIDTH + 1);
  localparam int MW0   = (RPW + 2 > CNT_W) ? RPW + 2 : CNT_W;
  localparam int MW    = ((MW0 > PW) ? MW0 : PW) + 1;
  localparam int LAST_SLOT_SAT = (ROW_STORE_DEPTH - 1) % 3;

  logic [RPW-1:0] row_pixels_r;
  logic [IRW-1:0] image_rows_r;
  logic           colour_mode_r;

  logic [CNT_W-1:0]       col_r, col_nxt;
  logic [1:0]             mod3_r, mod3_nxt;
  logic [IRW-1:0]         row_r, row_nxt;
  psu_pkg::filter_t       filt_r, filt_nxt;
  logic                   aborted_r, aborted_nxt;

  logic [BW-1:0] lh_r [3];
  logic [BW-1:0] ul_r [3];

  logic             p1_valid_r, p1_valid_nxt;
  logic             p1_err_r;
  logic [BW-1:0]    p1_byte_r;
  logic [AW-1:0]    p1_addr_r;
  logic [1:0]       p1_slot_r;
  logic             p1_aen_r;
  logic             p1_ben_r;
  psu_pkg::filter_t p1_filt_r;
  logic             p1_eor_r;
  logic             p1_eoi_r;
  logic             fwd_r;
  logic [BW-1:0]    fwd_data_r;

  logic             out_valid_r;
  logic [BW-1:0]    out_data_r;
  logic             out_last_r;
  logic [1:0]       out_user_r;

  logic           in_acc;
  logic           p1_move;
  logic           start;
  logic           aborted_eff;
  logic [CNT_W-1:0] col_eff;
  logic [1:0]     mod3_eff;
  logic [IRW-1:0] row_eff;
  logic [MW-1:0]  pix;
  logic [MW-1:0]  bytes_raw;
  logic [MW-1:0]  row_bytes;
  logic           bytes_sat;
  logic [1:0]     last3;
  logic [MW-1:0]  sm1;
  logic           s_sat;
  logic [MW-1:0]  s_full;
  logic [AW-1:0]  s_addr;
  logic [1:0]     slot;
  logic           last_col;
  logic           last_row;
  logic [IRW-1:0] rows;
  logic           take_sample;
  logic           take_err;
  logic           s_aen;
  logic [BW-1:0]  ram_rdata;
  logic [BW-1:0]  av, bv, cv, bmem, xv;
  logic [BW:0]    avg_sum;

  assign cfg_ready = 1'b1;
  assign in_tready = !p1_valid_r || p1_move;
  assign in_acc    = in_tvalid && in_tready;
  assign p1_move   = p1_valid_r && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pixels_r  <= RPW'(1);
      image_rows_r  <= IRW'(1);
      colour_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        psu_pkg::REG_ROW_PIXELS:  row_pixels_r  <= cfg_data[RPW-1:0];
        psu_pkg::REG_IMAGE_ROWS:  image_rows_r  <= cfg_data[IRW-1:0];
        psu_pkg::REG_COLOUR_MODE: colour_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    start       = in_tuser[0];
    aborted_eff = aborted_r && !start;
    col_eff     = start ? '0 : col_r;
    mod3_eff    = start ? 2'd0 : mod3_r;
    row_eff     = start ? '0 : row_r;

    pix = (row_pixels_r == '0) ? MW'(1) : MW'(row_pixels_r);
    if (pix > MW'(MAX_WIDTH)) begin
      pix = MW'(MAX_WIDTH);
    end
    bytes_raw = colour_mode_r ? (pix + (pix << 1)) : pix;
    bytes_sat = bytes_raw > MW'(ROW_STORE_DEPTH);
    row_bytes = bytes_sat ? MW'(ROW_STORE_DEPTH) : bytes_raw;
    last3     = !colour_mode_r ? 2'd0 : (bytes_sat ? 2'(LAST_SLOT_SAT) : 2'd2);

    sm1      = MW'(col_eff) - MW'(1);
    s_sat    = sm1 >= row_bytes;
    s_full   = s_sat ? (row_bytes - MW'(1)) : sm1;
    s_addr   = s_full[AW-1:0];
    slot     = !colour_mode_r ? 2'd0 : (s_sat ? last3 : mod3_eff);
    last_col = s_full == (row_bytes - MW'(1));
    s_aen    = colour_mode_r ? (s_full >= MW'(3)) : (s_full >= MW'(1));
    rows     = (image_rows_r == '0) ? IRW'(1) : image_rows_r;
    last_row = ({1'b0, row_eff} + 17'd1) >= {1'b0, rows};

    take_sample = in_acc && !aborted_eff && (col_eff != '0);
    take_err    = in_acc && !aborted_eff && (col_eff == '0) &&
                  (in_tdata > psu_pkg::FILT_MAX_CODE);

    col_nxt      = col_r;
    mod3_nxt     = mod3_r;
    row_nxt      = row_r;
    filt_nxt     = filt_r;
    aborted_nxt  = aborted_r;
    if (in_acc) begin
      col_nxt     = col_eff;
      mod3_nxt    = mod3_eff;
      row_nxt     = row_eff;
      filt_nxt    = start ? psu_pkg::FILT_NONE : filt_r;
      aborted_nxt = aborted_eff;
      if (!aborted_eff) begin
        if (col_eff == '0) begin
          if (in_tdata > psu_pkg::FILT_MAX_CODE) begin
            aborted_nxt = 1'b1;
          end else begin
            filt_nxt = in_tdata[2:0];
            col_nxt  = CNT_W'(1);
            mod3_nxt = 2'd0;
          end
        end else begin
          if (last_col) begin
            col_nxt = '0;
            row_nxt = last_row ? '0 : row_eff + IRW'(1);
          end else begin
            col_nxt  = col_eff + CNT_W'(1);
            mod3_nxt = (mod3_eff == 2'd2) ? 2'd0 : mod3_eff + 2'd1;
          end
        end
      end
    end

    p1_valid_nxt = p1_valid_r;
    if (take_sample || take_err) begin
      p1_valid_nxt = 1'b1;
    end else if (p1_move) begin
      p1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      mod3_r      <= 2'd0;
      row_r       <= '0;
      filt_r      <= psu_pkg::FILT_NONE;
      aborted_r   <= 1'b0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      mod3_r     <= mod3_nxt;
      row_r      <= row_nxt;
      filt_r     <= filt_nxt;
      aborted_r  <= aborted_nxt;
      p1_valid_r <= p1_valid_nxt;
      if (p1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  psu_ram #(
    .WIDTH(BW),
    .DEPTH(ROW_STORE_DEPTH)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (p1_move && !p1_err_r),
    .wr_addr(p1_addr_r),
    .wr_data(xv),
    .rd_en  (take_sample),
    .rd_addr(s_addr),
    .rd_data(ram_rdata)
  );

  always_comb begin
    bmem    = fwd_r ? fwd_data_r : ram_rdata;
    av      = p1_aen_r ? lh_r[p1_slot_r] : '0;
    bv      = p1_ben_r ? bmem : '0;
    cv      = (p1_ben_r && p1_aen_r) ? ul_r[p1_slot_r] : '0;
    avg_sum = {1'b0, av} + {1'b0, bv};
    case (p1_filt_r)
      psu_pkg::FILT_SUB:   xv = p1_byte_r + av;
      psu_pkg::FILT_UP:    xv = p1_byte_r + bv;
      psu_pkg::FILT_AVG:   xv = p1_byte_r + avg_sum[BW:1];
      psu_pkg::FILT_PAETH: xv = p1_byte_r + psu_pkg::paeth(av, bv, cv);
      default:             xv = p1_byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        lh_r[i] <= '0;
        ul_r[i] <= '0;
      end
    end else if (in_acc && start) begin
      for (int i = 0; i < 3; i++) begin
        lh_r[i] <= '0;
        ul_r[i] <= '0;
      end
    end else if (p1_move && !p1_err_r) begin
      lh_r[p1_slot_r] <= xv;
      ul_r[p1_slot_r] <= bv;
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample || take_err) begin
      p1_err_r   <= take_err;
      p1_byte_r  <= in_tdata;
      p1_addr_r  <= s_addr;
      p1_slot_r  <= slot;
      p1_aen_r   <= s_aen;
      p1_ben_r   <= row_eff != '0;
      p1_filt_r  <= filt_r;
      p1_eor_r   <= take_sample && last_col;
      p1_eoi_r   <= take_sample && last_col && last_row;
      fwd_r      <= p1_move && !p1_err_r && (p1_addr_r == s_addr);
      fwd_data_r <= xv;
    end
    if (p1_move) begin
      out_data_r <= p1_err_r ? '0 : xv;
      out_last_r <= p1_eor_r;
      out_user_r <= {p1_err_r, p1_eoi_r};
    end
  end

`ifndef SYNTH
  a_err_sets_abort: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && p1_err_r |-> aborted_r)
    else $error("error request in flight without abort flag");

  a_err_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0 && !out_tlast && !out_tuser[0])
    else $error("error result carries sample data");

  a_eoi_has_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("end of image without end of row");

  a_mod3_range: assert property (@(posedge clk) disable iff (!rst_n)
    mod3_r != 2'd3)
    else $error("slot counter out of range");

  a_no_write_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    p1_move && p1_err_r |=> !out_tlast)
    else $error("error request marked as row end");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int N_SETUPS       = 12;
  localparam int HOLD_SETUP     = 2;

  typedef struct packed {
    logic [7:0] px;
    logic       eor;
    logic       eoi;
    logic       bad;
  } pix_result_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [psu_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [15:0]                    value;
    logic                           first;
    logic                           typed;
    pix_result_t                    want;
  } dir_row_t;

  typedef struct packed {
    logic [11:0] pixels;
    logic [15:0] rows;
    logic        rgb;
    logic [12:0] count;
    logic        noisy;
    logic        fresh;
    logic        fast;
  } img_setup_t;

  localparam pix_result_t NO_PX = '0;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata   = '0;
  logic [0:0]                     in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;
  logic                           out_tlast;
  logic [1:0]                     out_tuser;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  // Predictor state: configuration copy, line store, histories and counters.
  int unsigned      width_px    = 1;
  int unsigned      height_rows = 1;
  bit               rgb_mode    = 1'b0;
  logic [7:0]       line_mem [psu_pkg::ROW_STORE_DEPTH_DEF];
  logic [7:0]       left_px [3];
  logic [7:0]       upleft_px [3];
  int               col_pos;
  int               row_pos;
  psu_pkg::filter_t cur_filter;
  bit               halted;

  pix_result_t expected_px [$];
  dir_row_t    directed [$];

  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  bit rx_hold = 1'b0;

  int error_count  = 0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int rows_seen    = 0;
  int aborts_seen  = 0;

  // Widths 2047 and 1024 are the only large widths and run without idling.
  img_setup_t setups [N_SETUPS] = '{
    '{12'd1,    16'd1,     1'b0, 13'd40,   1'b1, 1'b1, 1'b0},
    '{12'd4,    16'd3,     1'b0, 13'd60,   1'b1, 1'b1, 1'b0},
    '{12'd3,    16'd4,     1'b1, 13'd80,   1'b1, 1'b1, 1'b0},
    '{12'd7,    16'd65535, 1'b0, 13'd80,   1'b1, 1'b1, 1'b0},
    '{12'd0,    16'd0,     1'b1, 13'd30,   1'b1, 1'b1, 1'b0},
    '{12'd5,    16'd2,     1'b1, 13'd60,   1'b1, 1'b1, 1'b1},
    '{12'd2,    16'd2,     1'b1, 13'd40,   1'b1, 1'b0, 1'b0},
    '{12'd2,    16'd1,     1'b0, 13'd30,   1'b1, 1'b0, 1'b0},
    '{12'd2047, 16'd2,     1'b1, 13'd150,  1'b0, 1'b1, 1'b1},
    '{12'd1024, 16'd1,     1'b0, 13'd80,   1'b0, 1'b1, 1'b1},
    '{12'd9,    16'd6,     1'b0, 13'd70,   1'b1, 1'b1, 1'b0},
    '{12'd6,    16'd3,     1'b1, 13'd60,   1'b1, 1'b1, 1'b0}
  };

  png_scanline_unfilter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_image_state();
    for (int i = 0; i < 3; i++) begin
      left_px[i]   = '0;
      upleft_px[i] = '0;
    end
    col_pos    = 0;
    row_pos    = 0;
    cur_filter = psu_pkg::FILT_NONE;
    halted     = 1'b0;
  endfunction

  function automatic void unfilter_byte(input logic [7:0] din, input logic first,
                                        output bit taken, output bit has_px,
                                        output pix_result_t res);
    int bpp, npix, nrows, row_len, s, slot;
    int a, b, c, p, pa, pb, pc, pred, x;
    bit last_col, last_row;
    taken  = 1'b1;
    has_px = 1'b0;
    res    = NO_PX;
    if (first) begin
      clear_image_state();
    end
    if (halted) begin
      taken = 1'b0;
      return;
    end
    if (col_pos == 0) begin
      if (din > psu_pkg::FILT_MAX_CODE) begin
        halted  = 1'b1;
        has_px  = 1'b1;
        res.bad = 1'b1;
        return;
      end
      cur_filter = psu_pkg::filter_t'(din[2:0]);
      col_pos    = 1;
      return;
    end
    bpp = rgb_mode ? 3 : 1;
    npix = (width_px == 0) ? 1 : int'(width_px);
    if (npix > psu_pkg::MAX_WIDTH_DEF) begin
      npix = psu_pkg::MAX_WIDTH_DEF;
    end
    row_len = npix * bpp;
    if (row_len > psu_pkg::ROW_STORE_DEPTH_DEF) begin
      row_len = psu_pkg::ROW_STORE_DEPTH_DEF;
    end
    nrows = (height_rows == 0) ? 1 : int'(height_rows);
    s = col_pos - 1;
    if (s >= row_len) begin
      s = row_len - 1;
    end
    slot = s % bpp;
    a = (s >= bpp) ? int'(left_px[slot]) : 0;
    b = (row_pos > 0) ? int'(line_mem[s]) : 0;
    c = (row_pos > 0 && s >= bpp) ? int'(upleft_px[slot]) : 0;

    p  = a + b - c;
    pa = (p > a) ? p - a : a - p;
    pb = (p > b) ? p - b : b - p;
    pc = (p > c) ? p - c : c - p;
    if (pa <= pb && pa <= pc) begin
      pred = a;
    end else if (pb <= pc) begin
      pred = b;
    end else begin
      pred = c;
    end

    case (cur_filter)
      psu_pkg::FILT_SUB:   x = din + a;
      psu_pkg::FILT_UP:    x = din + b;
      psu_pkg::FILT_AVG:   x = din + ((a + b) >> 1);
      psu_pkg::FILT_PAETH: x = din + pred;
      default:             x = din;
    endcase

    left_px[slot]   = 8'(x);
    upleft_px[slot] = 8'(b);
    line_mem[s]     = 8'(x);

    last_col = (s == row_len - 1);
    last_row = (row_pos + 1 >= nrows);
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((row_pos + 1) & 16'hFFFF);
    end else begin
      col_pos = s + 2;
    end

    has_px  = 1'b1;
    res.px  = 8'(x);
    res.eor = last_col;
    res.eoi = last_col && last_row;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
    error_count++;
  endtask

  task automatic check_pixel();
    pix_result_t want;
    if (expected_px.size() == 0) begin
      report_mismatch($sformatf("output byte %02h with no request pending", out_tdata));
      return;
    end
    want = expected_px.pop_front();
    if (out_tdata !== want.px) begin
      report_mismatch($sformatf("pixel_byte %02h, expected %02h", out_tdata, want.px));
    end
    if (out_tlast !== want.eor) begin
      report_mismatch($sformatf("end_of_row %b, expected %b", out_tlast, want.eor));
    end
    if (out_tuser[0] !== want.eoi) begin
      report_mismatch($sformatf("end_of_image %b, expected %b", out_tuser[0], want.eoi));
    end
    if (out_tuser[1] !== want.bad) begin
      report_mismatch($sformatf("bad_filter %b, expected %b", out_tuser[1], want.bad));
    end
    results_seen++;
    if (want.eor) begin
      rows_seen++;
    end
    if (want.bad) begin
      aborts_seen++;
    end
  endtask

  task automatic send_byte(input logic [7:0] din, input logic first, input bit typed,
                           input pix_result_t want, output bit taken);
    int gap;
    bit has_px;
    pix_result_t res;
    gap = tx_fast ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= din;
    in_tuser  <= first;
    do @(posedge clk); while (in_tready !== 1'b1);
    unfilter_byte(din, first, taken, has_px, res);
    if (has_px) begin
      expected_px.push_back(typed ? want : res);
    end
    bytes_sent++;
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [psu_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[psu_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      psu_pkg::REG_ROW_PIXELS:  width_px    = value % (1 << psu_pkg::ROW_PIXELS_W);
      psu_pkg::REG_IMAGE_ROWS:  height_rows = value % (1 << psu_pkg::IMAGE_ROWS_W);
      psu_pkg::REG_COLOUR_MODE: rgb_mode    = value[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_byte(input int unsigned value, input bit first,
                                   input bit typed, input pix_result_t want);
    directed.push_back('{ROW_BYTE, psu_pkg::REG_ROW_PIXELS, 16'(value), first, typed, want});
  endfunction

  function automatic void add_reg(input logic [psu_pkg::CFG_IDX_W-1:0] idx,
                                  input int unsigned value);
    directed.push_back('{ROW_REG, idx, 16'(value), 1'b0, 1'b0, NO_PX});
  endfunction

  // Result checking runs on its own so that stalls land on any phase of the work.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        stall = rx_fast ? 0 : $urandom_range(0, 11);
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      check_pixel();
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog: no request accepted for %0d cycles.", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    bit          taken;
    bit          start;
    bit          first_item;
    logic [7:0]  din;
    int          taken_cnt;
    img_setup_t  su;

    foreach (line_mem[i]) begin
      line_mem[i] = '0;
    end
    clear_image_state();

    add_byte(psu_pkg::FILT_NONE, 1, 0, NO_PX);
    add_byte(8'h00, 0, 1, pix_result_t'{8'h00, 1'b1, 1'b1, 1'b0});
    add_byte(psu_pkg::FILT_NONE, 0, 0, NO_PX);
    add_byte(8'hFF, 0, 1, pix_result_t'{8'hFF, 1'b1, 1'b1, 1'b0});
    add_byte(psu_pkg::FILT_MAX_CODE + 1, 0, 1, pix_result_t'{8'h00, 1'b0, 1'b0, 1'b1});
    add_byte(8'h33, 0, 0, NO_PX);
    add_byte(8'hFF, 1, 1, pix_result_t'{8'h00, 1'b0, 1'b0, 1'b1});
    add_byte(psu_pkg::FILT_SUB, 1, 0, NO_PX);
    add_byte(8'hA5, 0, 0, NO_PX);
    add_byte(psu_pkg::FILT_UP, 0, 0, NO_PX);
    add_byte(8'h5A, 0, 0, NO_PX);
    add_byte(psu_pkg::FILT_AVG, 0, 0, NO_PX);
    add_byte(8'hFF, 0, 0, NO_PX);
    add_byte(psu_pkg::FILT_PAETH, 0, 0, NO_PX);
    add_byte(8'h01, 0, 0, NO_PX);
    add_reg(psu_pkg::REG_ROW_PIXELS, 0);
    add_reg(psu_pkg::REG_IMAGE_ROWS, 0);
    add_byte(psu_pkg::FILT_NONE, 1, 0, NO_PX);
    add_byte(8'h3C, 0, 1, pix_result_t'{8'h3C, 1'b1, 1'b1, 1'b0});
    add_reg(psu_pkg::REG_ROW_PIXELS, 2);
    add_reg(psu_pkg::REG_IMAGE_ROWS, 3);
    add_byte(psu_pkg::FILT_SUB, 1, 0, NO_PX);
    add_byte(8'hF0, 0, 0, NO_PX);
    add_byte(8'h20, 0, 0, NO_PX);
    add_byte(psu_pkg::FILT_UP, 0, 0, NO_PX);
    add_byte(8'h10, 0, 0, NO_PX);
    add_byte(8'hFF, 0, 0, NO_PX);
    add_byte(psu_pkg::FILT_PAETH, 0, 0, NO_PX);
    add_byte(8'h80, 0, 0, NO_PX);
    add_byte(8'h7F, 0, 0, NO_PX);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) begin
        wait_results_done();
        write_reg(directed[i].reg_idx, directed[i].value);
      end else begin
        send_byte(directed[i].value[7:0], directed[i].first, directed[i].typed,
                  directed[i].want, taken);
      end
    end

    // Setups that do not start a fresh image only shrink the row, so the rows
    // above are always written before they are read.
    for (int k = 0; k < N_SETUPS; k++) begin
      su = setups[k];
      wait_results_done();
      write_reg(psu_pkg::REG_ROW_PIXELS, su.pixels);
      write_reg(psu_pkg::REG_IMAGE_ROWS, su.rows);
      write_reg(psu_pkg::REG_COLOUR_MODE, su.rgb);
      tx_fast = su.fast;
      rx_fast = su.fast;
      if (k == HOLD_SETUP) begin
        rx_hold = 1'b1;
      end
      taken_cnt  = 0;
      first_item = su.fresh;
      while (taken_cnt < su.count) begin
        start = first_item || (su.noisy && $urandom_range(0, 79) == 0) ||
                (halted && $urandom_range(0, 2) == 0);
        if (halted && !start) begin
          din = 8'($urandom);
        end else if (start || col_pos == 0) begin
          if (su.noisy && $urandom_range(0, 29) == 0) begin
            din = 8'($urandom_range(psu_pkg::FILT_MAX_CODE + 1, 255));
          end else begin
            din = 8'($urandom_range(0, psu_pkg::FILT_MAX_CODE));
          end
        end else begin
          case ($urandom_range(0, 9))
            0:       din = 8'h00;
            1:       din = 8'hFF;
            default: din = 8'($urandom);
          endcase
        end
        send_byte(din, start, 1'b0, NO_PX, taken);
        if (taken) begin
          taken_cnt++;
        end
        first_item = 1'b0;
      end
    end

    wait_results_done();
    $display("Covered %0d input bytes, %0d checked output bytes, %0d rows, %0d filter aborts.",
             bytes_sent, results_seen, rows_seen, aborts_seen);
    $display("Ran %0d image setups: widths 0 to 2047, heights 0 to 65535, grey and RGB.",
             N_SETUPS + 1);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
sv/psu_pkg.sv
sv/psu_ram.sv
sv/png_scanline_unfilter_unit.sv
sim/testbench.sv
